### rtl/prdg_pkg.sv
// ----------------------------------------------------------------------------
// prdg_pkg: shared types and constants
// Register map codes, queue entry type and CORDIC angle table for the
// primary ray direction generator.
// ----------------------------------------------------------------------------
package prdg_pkg;

	// register indexes on the config port
	localparam logic [2:0] REG_CAM_PITCH = 3'd0;
	localparam logic [2:0] REG_CAM_YAW   = 3'd1;
	localparam logic [2:0] REG_CAM_POS_X = 3'd2;
	localparam logic [2:0] REG_CAM_POS_Y = 3'd3;
	localparam logic [2:0] REG_CAM_POS_Z = 3'd4;
	localparam logic [2:0] REG_BUF_W     = 3'd5;
	localparam logic [2:0] REG_BUF_H     = 3'd6;

	localparam int TAB_LEN = 24;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] STAGE_ANGLE [TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] VEC_X0       = 32'sd13107200; // 200 in Q.16
	localparam logic signed [20:0] DIR_SCALE    = 21'sd512000;   // 2000 in Q.8

	// one classified pixel between front and back
	typedef struct packed {
		logic        [23:0] idx;
		logic signed [13:0] dx;
		logic signed [13:0] dy;
	} prdg_item_t;

endpackage

### rtl/prdg_fifo.sv
// ----------------------------------------------------------------------------
// prdg_fifo: short decoupling queue
// Small register queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module prdg_fifo import prdg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  prdg_item_t wdata,
	output logic       full,
	input  logic       rd,
	output logic       avail,
	output prdg_item_t rdata
);
	localparam int DEPTH = 4;

	prdg_item_t  mem_q [DEPTH];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;

	assign full  = (cnt_q == 3'(DEPTH));
	assign avail = (cnt_q != 3'd0);
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 2'd1;
			if (rd && avail) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr && !full) - 3'(rd && avail);
		end
	end
endmodule

### rtl/prdg_front.sv
// ----------------------------------------------------------------------------
// prdg_front: pixel intake
// Clamps the image size, forms the ray index and centered offsets, and
// hands the beat to the queue through one register stage.
// ----------------------------------------------------------------------------
module prdg_front import prdg_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic [12:0] buf_w,
	input  logic [12:0] buf_h,
	output logic        q_wr,
	output prdg_item_t  q_data,
	input  logic        q_full
);
	localparam logic [13:0] DIM_CAP = 14'(MAX_DIM);

	logic [13:0] wc, hc;
	prdg_item_t  item;
	prdg_item_t  item_s1;
	logic        vld_s1;

	// clamp and classify
	always_comb begin
		wc = ({1'b0, buf_w} > DIM_CAP) ? DIM_CAP : {1'b0, buf_w};
		hc = ({1'b0, buf_h} > DIM_CAP) ? DIM_CAP : {1'b0, buf_h};
		item.idx = 24'(26'(pixel_y) * 26'(wc)) + 24'(pixel_x);
		item.dx  = $signed({2'b00, pixel_x}) - $signed({1'b0, wc[13:1]});
		item.dy  = $signed({2'b00, pixel_y}) - $signed({1'b0, hc[13:1]});
	end

	assign full   = vld_s1 && q_full;
	assign q_wr   = vld_s1;
	assign q_data = item_s1;

	always_ff @(posedge clk) begin
		if (push && !full) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (push && !full) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end
endmodule

### rtl/prdg_back.sv
// ----------------------------------------------------------------------------
// prdg_back: direction pipeline
// Two vectoring CORDICs for the angles, two rotation CORDICs for sin/cos,
// then the scaling products, ending in the result register.
// ----------------------------------------------------------------------------
module prdg_back import prdg_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_avail,
	input  prdg_item_t         q_data,
	output logic               q_rd,
	input  logic [15:0]        cam_pitch,
	input  logic [15:0]        cam_yaw,
	output logic               empty,
	input  logic               pop,
	output logic        [23:0] ray_index,
	output logic signed [23:0] dir_x,
	output logic signed [23:0] dir_y,
	output logic signed [23:0] dir_z
);
	localparam int N   = CORDIC_STAGES;
	localparam int LAT = 2 * N + 6;

	logic            en;
	logic [LAT-1:0]  vld_q;
	logic [23:0]     idx_q [LAT];

	// vectoring: p* pitch, y* yaw; index 0 is the entry stage
	logic signed [31:0] pvx_s2 [N+1], pvy_s2 [N+1], pvz_s2 [N+1];
	logic signed [31:0] yvx_s2 [N+1], yvy_s2 [N+1], yvz_s2 [N+1];
	// rotation; index 0 is the angle fold stage
	logic signed [31:0] prx_s4 [N+1], pry_s4 [N+1], prz_s4 [N+1];
	logic signed [31:0] yrx_s4 [N+1], yry_s4 [N+1], yrz_s4 [N+1];
	logic               pfl_s4 [N+1], yfl_s4 [N+1];

	logic signed [31:0] pa, ya, cp, sp, cq, sq;
	logic signed [63:0] pcc_s5, pcs_s5, psy_s5;
	logic signed [31:0] rcc_s6, rcs_s6;
	logic signed [63:0] psy_s6, qx_s7, qz_s7, psy_s7;
	logic signed [63:0] rx, rz, ry;
	logic signed [23:0] dx_s8, dy_s8, dz_s8;

	// whole pipeline advances unless the result is held
	assign en        = !vld_q[LAT-1] || pop;
	assign q_rd      = en && q_avail;
	assign empty     = !vld_q[LAT-1];
	assign ray_index = idx_q[LAT-1];
	assign dir_x     = dx_s8;
	assign dir_y     = dy_s8;
	assign dir_z     = dz_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], q_avail};
	end

	// index shift line
	always_ff @(posedge clk) begin
		if (en) begin
			idx_q[0] <= q_data.idx;
			for (int k = 1; k < LAT; k++) idx_q[k] <= idx_q[k-1];
		end
	end

	// entry: load vectoring start values
	always_ff @(posedge clk) begin
		if (en) begin
			pvx_s2[0] <= VEC_X0;
			pvy_s2[0] <= $signed({{18{q_data.dy[13]}}, q_data.dy}) <<< 16;
			pvz_s2[0] <= '0;
			yvx_s2[0] <= VEC_X0;
			yvy_s2[0] <= $signed({{18{q_data.dx[13]}}, q_data.dx}) <<< 16;
			yvz_s2[0] <= '0;
		end
	end

	// CORDIC stages
	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic signed [31:0] ANG = $signed(STAGE_ANGLE[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (pvy_s2[k] >= 0) begin
					pvx_s2[k+1] <= pvx_s2[k] + (pvy_s2[k] >>> k);
					pvy_s2[k+1] <= pvy_s2[k] - (pvx_s2[k] >>> k);
					pvz_s2[k+1] <= pvz_s2[k] + ANG;
				end else begin
					pvx_s2[k+1] <= pvx_s2[k] - (pvy_s2[k] >>> k);
					pvy_s2[k+1] <= pvy_s2[k] + (pvx_s2[k] >>> k);
					pvz_s2[k+1] <= pvz_s2[k] - ANG;
				end
				if (yvy_s2[k] >= 0) begin
					yvx_s2[k+1] <= yvx_s2[k] + (yvy_s2[k] >>> k);
					yvy_s2[k+1] <= yvy_s2[k] - (yvx_s2[k] >>> k);
					yvz_s2[k+1] <= yvz_s2[k] + ANG;
				end else begin
					yvx_s2[k+1] <= yvx_s2[k] - (yvy_s2[k] >>> k);
					yvy_s2[k+1] <= yvy_s2[k] + (yvx_s2[k] >>> k);
					yvz_s2[k+1] <= yvz_s2[k] - ANG;
				end
				if (prz_s4[k] >= 0) begin
					prx_s4[k+1] <= prx_s4[k] - (pry_s4[k] >>> k);
					pry_s4[k+1] <= pry_s4[k] + (prx_s4[k] >>> k);
					prz_s4[k+1] <= prz_s4[k] - ANG;
				end else begin
					prx_s4[k+1] <= prx_s4[k] + (pry_s4[k] >>> k);
					pry_s4[k+1] <= pry_s4[k] - (prx_s4[k] >>> k);
					prz_s4[k+1] <= prz_s4[k] + ANG;
				end
				if (yrz_s4[k] >= 0) begin
					yrx_s4[k+1] <= yrx_s4[k] - (yry_s4[k] >>> k);
					yry_s4[k+1] <= yry_s4[k] + (yrx_s4[k] >>> k);
					yrz_s4[k+1] <= yrz_s4[k] - ANG;
				end else begin
					yrx_s4[k+1] <= yrx_s4[k] + (yry_s4[k] >>> k);
					yry_s4[k+1] <= yry_s4[k] - (yrx_s4[k] >>> k);
					yrz_s4[k+1] <= yrz_s4[k] + ANG;
				end
				pfl_s4[k+1] <= pfl_s4[k];
				yfl_s4[k+1] <= yfl_s4[k];
			end
		end
	end

	// add camera angle, fold into a quarter turn either side
	assign pa = $signed({cam_pitch, 16'h0000}) + pvz_s2[N];
	assign ya = $signed({cam_yaw, 16'h0000}) + yvz_s2[N];

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s4[0] <= INV_GAIN_Q30;
			pry_s4[0] <= '0;
			yrx_s4[0] <= INV_GAIN_Q30;
			yry_s4[0] <= '0;
			pfl_s4[0] <= (pa > 32'sh4000_0000) || (pa < -32'sh4000_0000);
			yfl_s4[0] <= (ya > 32'sh4000_0000) || (ya < -32'sh4000_0000);
			if ((pa > 32'sh4000_0000) || (pa < -32'sh4000_0000))
				prz_s4[0] <= $signed({~pa[31], pa[30:0]});
			else
				prz_s4[0] <= pa;
			if ((ya > 32'sh4000_0000) || (ya < -32'sh4000_0000))
				yrz_s4[0] <= $signed({~ya[31], ya[30:0]});
			else
				yrz_s4[0] <= ya;
		end
	end

	// half-turn fold negates sin and cos
	assign cp = pfl_s4[N] ? -prx_s4[N] : prx_s4[N];
	assign sp = pfl_s4[N] ? -pry_s4[N] : pry_s4[N];
	assign cq = yfl_s4[N] ? -yrx_s4[N] : yrx_s4[N];
	assign sq = yfl_s4[N] ? -yry_s4[N] : yry_s4[N];

	// round to nearest, halves up
	assign rx = (qx_s7 + 64'sd536870912) >>> 30;
	assign rz = (qz_s7 + 64'sd536870912) >>> 30;
	assign ry = (psy_s7 + 64'sd536870912) >>> 30;

	// products and scaling
	always_ff @(posedge clk) begin
		if (en) begin
			pcc_s5 <= 64'(cp) * 64'(cq);
			pcs_s5 <= 64'(cp) * 64'(sq);
			psy_s5 <= 64'(sp) * 64'(DIR_SCALE);
			rcc_s6 <= 32'((pcc_s5 + 64'sd536870912) >>> 30);
			rcs_s6 <= 32'((pcs_s5 + 64'sd536870912) >>> 30);
			psy_s6 <= psy_s5;
			qx_s7  <= 64'(rcc_s6) * 64'(DIR_SCALE);
			qz_s7  <= 64'(rcs_s6) * 64'(DIR_SCALE);
			psy_s7 <= psy_s6;
			dx_s8  <= rx[23:0];
			dy_s8  <= ry[23:0];
			dz_s8  <= rz[23:0];
		end
	end

	// checks on the stall logic
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved while stalled");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(en && q_avail) |=> vld_q[0])
		else $error("queue beat lost at pipeline entry");
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !q_avail) |=> !vld_q[0])
		else $error("beat invented at pipeline entry");
endmodule

### rtl/primary_ray_direction_gen_core.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_gen_core: primary ray generator top level
// Throughput: one pixel per cycle while the result is popped, set by the fully pipelined CORDICs.
// The whole back pipeline holds together while a result waits for pop.
// Reset: asynchronous; clears all valid state and loads the register
// defaults (yaw quarter turn, 640x480 image).
// ----------------------------------------------------------------------------
module primary_ray_direction_gen_core import prdg_pkg::*; #(
	parameter int MAX_DIM       = 4096,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic        [11:0] pixel_x,
	input  logic        [11:0] pixel_y,
	output logic               empty,
	input  logic               pop,
	output logic        [23:0] ray_index,
	output logic signed [31:0] origin_x,
	output logic signed [31:0] origin_y,
	output logic signed [31:0] origin_z,
	output logic signed [23:0] dir_x,
	output logic signed [23:0] dir_y,
	output logic signed [23:0] dir_z,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [4:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);
	logic [15:0] pitch_q, yaw_q;
	logic [31:0] posx_q, posy_q, posz_q;
	logic [12:0] bufw_q, bufh_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	logic        q_wr, q_full, q_rd, q_avail;
	prdg_item_t  q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= 16'd0;
			yaw_q   <= 16'd16384;
			posx_q  <= '0;
			posy_q  <= '0;
			posz_q  <= '0;
			bufw_q  <= 13'd640;
			bufh_q  <= 13'd480;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CAM_PITCH: pitch_q <= pwdata[15:0];
				REG_CAM_YAW:   yaw_q   <= pwdata[15:0];
				REG_CAM_POS_X: posx_q  <= pwdata;
				REG_CAM_POS_Y: posy_q  <= pwdata;
				REG_CAM_POS_Z: posz_q  <= pwdata;
				REG_BUF_W:     bufw_q  <= pwdata[12:0];
				REG_BUF_H:     bufh_q  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_CAM_PITCH: prdata = {16'h0000, pitch_q};
			REG_CAM_YAW:   prdata = {16'h0000, yaw_q};
			REG_CAM_POS_X: prdata = posx_q;
			REG_CAM_POS_Y: prdata = posy_q;
			REG_CAM_POS_Z: prdata = posz_q;
			REG_BUF_W:     prdata = {19'h0, bufw_q};
			REG_BUF_H:     prdata = {19'h0, bufh_q};
			default:       prdata = '0;
		endcase
	end

	// origin is the camera position; the user must keep it stable while items are in flight, the block does not enforce it
	assign origin_x = posx_q;
	assign origin_y = posy_q;
	assign origin_z = posz_q;

	prdg_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.buf_w   (bufw_q),
		.buf_h   (bufh_q),
		.q_wr    (q_wr),
		.q_data  (q_wdata),
		.q_full  (q_full)
	);

	prdg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.avail  (q_avail),
		.rdata  (q_rdata)
	);

	prdg_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.q_data    (q_rdata),
		.q_rd      (q_rd),
		.cam_pitch (pitch_q),
		.cam_yaw   (yaw_q),
		.empty     (empty),
		.pop       (pop),
		.ray_index (ray_index),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z)
	);
endmodule

### tb/prdg_ray_checker.sv
// ----------------------------------------------------------------------------
// prdg_ray_checker: ray prediction and result scoreboard
// Mirrors the camera registers from the config port, predicts the ray of
// every accepted pixel beat and compares each popped ray field by field.
// ----------------------------------------------------------------------------
module prdg_ray_checker import prdg_pkg::*; #(
	parameter int MAX_DIM       = 4096,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic        [11:0] pixel_x,
	input  logic        [11:0] pixel_y,
	input  logic               empty,
	input  logic               pop,
	input  logic        [23:0] ray_index,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [23:0] dir_x,
	input  logic signed [23:0] dir_y,
	input  logic signed [23:0] dir_z,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [4:0]  paddr,
	input  logic        [31:0] pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        [23:0] idx;
		logic signed [31:0] ox, oy, oz;
		logic signed [23:0] dx, dy, dz;
	} ray_t;

	// register mirror
	logic [15:0] m_pitch, m_yaw;
	logic [31:0] m_px, m_py, m_pz;
	logic [12:0] m_w, m_h;

	ray_t rays_due[$];

	assign pending = rays_due.size();

	// vectoring CORDIC: angle of (200, d) in 2^-32 turn
	function automatic longint offset_angle(longint d);
		longint x, y, z, xs, ys;
		x = 200 * 65536;
		y = d * 65536;
		z = 0;
		for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(STAGE_ANGLE[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(STAGE_ANGLE[i]);
			end
		end
		return z;
	endfunction

	// rotation CORDIC with half-turn fold, results Q1.30
	function automatic void angle_sincos(input logic [31:0] a, output longint c,
			output longint s);
		longint x, y, z, xs, ys;
		bit flip;
		z = longint'({32'd0, a});
		x = 652032874;
		y = 0;
		flip = 0;
		if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
		if (z > (64'sd1 <<< 30)) begin
			z -= (64'sd1 <<< 31); flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += (64'sd1 <<< 31); flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(STAGE_ANGLE[i]);
			end else begin
				x += ys; y -= xs; z += longint'(STAGE_ANGLE[i]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	function automatic longint rnd30(longint v);
		return (v + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py);
		ray_t r;
		longint w, h, cp, sp, cq, sq;
		logic [31:0] pitch, yaw, za, zb;
		w = m_w;
		h = m_h;
		if (w > MAX_DIM) w = MAX_DIM;
		if (h > MAX_DIM) h = MAX_DIM;
		za = 32'(offset_angle(longint'(py) - h / 2));
		zb = 32'(offset_angle(longint'(px) - w / 2));
		pitch = {m_pitch, 16'h0} + za;
		yaw = {m_yaw, 16'h0} + zb;
		angle_sincos(pitch, cp, sp);
		angle_sincos(yaw, cq, sq);
		r.idx = 24'(longint'(px) + longint'(py) * w);
		r.ox = m_px;
		r.oy = m_py;
		r.oz = m_pz;
		r.dy = 24'(rnd30(sp * 512000));
		r.dx = 24'(rnd30(rnd30(cp * cq) * 512000));
		r.dz = 24'(rnd30(rnd30(cp * sq) * 512000));
		return r;
	endfunction

	// config mirror, written on the APB access beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_pitch <= 16'd0;
			m_yaw <= 16'd16384;
			m_px <= '0;
			m_py <= '0;
			m_pz <= '0;
			m_w <= 13'd640;
			m_h <= 13'd480;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_CAM_PITCH: m_pitch <= pwdata[15:0];
				REG_CAM_YAW:   m_yaw <= pwdata[15:0];
				REG_CAM_POS_X: m_px <= pwdata;
				REG_CAM_POS_Y: m_py <= pwdata;
				REG_CAM_POS_Z: m_pz <= pwdata;
				REG_BUF_W:     m_w <= pwdata[12:0];
				REG_BUF_H:     m_h <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// scoreboard: compare popped beats, queue predictions of pushed beats
	initial errors = 0;
	always @(posedge clk) begin
		ray_t e;
		longint exp_f[7], act_f[7];
		string fname[7];
		if (arst_n) begin
			if (pop && !empty) begin
				if (rays_due.size() == 0) begin
					$display("%0t: ray beat with nothing expected, index %0d", $realtime,
						ray_index);
					errors++;
				end else begin
					e = rays_due.pop_front();
					fname = '{"ray_index", "origin_x", "origin_y", "origin_z",
						"dir_x", "dir_y", "dir_z"};
					exp_f = '{e.idx, e.ox, e.oy, e.oz, e.dx, e.dy, e.dz};
					act_f = '{ray_index, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
					for (int i = 0; i < 7; i++)
						if (exp_f[i] != act_f[i]) begin
							$display("%0t: %s expected %0d actual %0d", $realtime, fname[i],
								exp_f[i], act_f[i]);
							errors++;
						end
				end
			end
			if (push && !full)
				rays_due = {rays_due, predict_ray(pixel_x, pixel_y)};
		end
	end

endmodule

### tb/primary_ray_direction_gen_core_tb.sv
// ----------------------------------------------------------------------------
// primary_ray_direction_gen_core_tb: testbench top
// Drives pixel beats in random bursts under a series of camera settings,
// stalls the result side at random and reports the checker's verdict.
// ----------------------------------------------------------------------------
module primary_ray_direction_gen_core_tb import prdg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               push = 0;
	logic               full;
	logic        [11:0] pixel_x = '0;
	logic        [11:0] pixel_y = '0;
	logic               empty;
	logic               pop = 0;
	logic        [23:0] ray_index;
	logic signed [31:0] origin_x, origin_y, origin_z;
	logic signed [23:0] dir_x, dir_y, dir_z;
	logic               psel = 0;
	logic               penable = 0;
	logic               pwrite = 0;
	logic        [4:0]  paddr = '0;
	logic        [31:0] pwdata = '0;
	logic        [31:0] prdata;
	logic               pready;
	int                 errors, pending;
	int                 stall_pct = 0;
	int                 quiet = 0;
	int                 burst_left = 0;
	int                 cur_w = 640, cur_h = 480;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	primary_ray_direction_gen_core DUT (.*);

	prdg_ray_checker u_chk (.*);

	// result side stall pattern; rate changes every so often
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 90);
		pop <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog on beats of any kind
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable))
			quiet <= 0;
		else if (quiet >= STALL_LIMIT) begin
			$display("primary_ray_direction_gen_core: mismatch");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		push = 0;
		psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		if (idx == REG_BUF_W) cur_w = val[12:0];
		if (idx == REG_BUF_H) cur_h = val[12:0];
	endtask

	// wait for the pipeline to drain before touching the registers
	task automatic drain;
		@(negedge clk);
		push = 0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic camera_set(logic [15:0] p, logic [15:0] y, logic [31:0] x0,
			logic [31:0] y0, logic [31:0] z0, logic [12:0] w, logic [12:0] h);
		drain();
		reg_write(REG_CAM_PITCH, {16'h0000, p});
		reg_write(REG_CAM_YAW, {16'h0000, y});
		reg_write(REG_CAM_POS_X, x0);
		reg_write(REG_CAM_POS_Y, y0);
		reg_write(REG_CAM_POS_Z, z0);
		reg_write(REG_BUF_W, {19'h0, w});
		reg_write(REG_BUF_H, {19'h0, h});
	endtask

	// one pixel beat, with bursts and random gaps between them
	task automatic send_px(logic [11:0] x, logic [11:0] y);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				push = 0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		push = 1; pixel_x = x; pixel_y = y;
		do @(posedge clk); while (full);
	endtask

	task automatic send_rand_px;
		logic [11:0] x, y;
		if ($urandom_range(0, 9) == 0 || cur_w == 0 || cur_h == 0) begin
			x = 12'($urandom);
			y = 12'($urandom);
		end else begin
			x = 12'($urandom_range(0, (cur_w > 4096 ? 4096 : cur_w) - 1));
			y = 12'($urandom_range(0, (cur_h > 4096 ? 4096 : cur_h) - 1));
		end
		send_px(x, y);
	endtask

	function automatic logic [12:0] rand_dim;
		case ($urandom_range(0, 5))
			0: return 13'($urandom_range(0, 8191));
			1: return 13'($urandom_range(2048, 4096));
			default: return 13'($urandom_range(1, 200));
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset defaults: corners and center
		send_px(12'd0, 12'd0);
		send_px(12'd4095, 12'd4095);
		send_px(12'd639, 12'd479);
		send_px(12'd320, 12'd240);
		send_px(12'd0, 12'd4095);
		send_px(12'd4095, 12'd0);
		// zero size image
		camera_set(16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 13'd0, 13'd0);
		send_px(12'd0, 12'd0);
		send_px(12'd4095, 12'd4095);
		send_px(12'd7, 12'd3);
		// size above the max, angle and position extremes
		camera_set(16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			13'd8191, 13'd8191);
		send_px(12'd0, 12'd0);
		send_px(12'd4095, 12'd4095);
		send_px(12'd2048, 12'd2048);
		camera_set(16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			13'd4096, 13'd1);
		send_px(12'd4095, 12'd4095);
		send_px(12'd0, 12'd0);
		send_px(12'd2048, 12'd0);
		camera_set(16'h4000, 16'hC000, 32'h1234_5678, 32'hEDCB_A987, 32'h0,
			13'd1, 13'd4096);
		send_px(12'd0, 12'd0);
		send_px(12'd0, 12'd4095);
		send_px(12'd4095, 12'd2048);

		// random camera settings, well-formed pixels mostly inside the image
		for (int ph = 0; ph < 7; ph++) begin
			camera_set(16'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
				rand_dim(), rand_dim());
			repeat (245) send_rand_px();
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("primary_ray_direction_gen_core: match");
		else
			$display("primary_ray_direction_gen_core: mismatch");
		$finish;
	end

endmodule

### filelist.f
rtl/prdg_pkg.sv
rtl/prdg_fifo.sv
rtl/prdg_front.sv
rtl/prdg_back.sv
rtl/primary_ray_direction_gen_core.sv
tb/prdg_ray_checker.sv
tb/primary_ray_direction_gen_core_tb.sv
